FILE: sv/isss_pkg.sv
// Shared types and constants of the insertion-ordered set store.
package isss_pkg;

	localparam int DATA_W       = 32;
	localparam int COUNT_W      = 5;
	localparam int CAPACITY_DEF = 16;
	localparam int QUEUE_DEPTH  = 2;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	// A classified request as it travels from the front to the back.
	typedef struct packed {
		cmd_t               cmd;
		logic               needs_scan;
		logic [DATA_W-1:0]  value;
	} req_t;

endpackage

FILE: sv/isss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module isss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/isss_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module isss_front
	import isss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [1:0]        cmd,
	input  logic [DATA_W-1:0] value,
	output logic              q_valid,
	input  logic              q_pop,
	output req_t              q_data
);

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	req_t           entry_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] fill_q;
	req_t           classified;
	logic           push;
	logic           pop;

	always_comb begin
		classified.cmd        = cmd_t'(cmd);
		classified.needs_scan = (cmd_t'(cmd) != CMD_CLEAR);
		classified.value      = value;
	end

	assign req_stall = (fill_q == QCW'(QUEUE_DEPTH));
	assign push      = req_valid && !req_stall;
	assign q_valid   = (fill_q != '0);
	assign pop       = q_pop && q_valid;
	assign q_data    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/isss_back.sv
// Back end: scans the member memory, carries out each request and holds the result.
module isss_back
	import isss_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  req_t               q_data,
	output logic               res_valid,
	input  logic               res_stall,
	output logic               hit,
	output logic [COUNT_W-1:0] count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_RESP
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [DATA_W-1:0] val_q;
	logic [CW-1:0]     member_count_q;
	logic [CW-1:0]     scan_q;
	logic [CW-1:0]     sh_q;
	logic              chk_s1;
	logic [CW-1:0]     idx_s1;
	logic              wr_s1;
	logic [CW-1:0]     wr_addr_s1;
	logic              hit_q;
	logic              res_valid_q;
	logic              res_hit_q;
	logic [COUNT_W-1:0] res_count_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic              match;
	logic              scan_done;
	logic              has_room;
	logic              out_free;

	isss_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_members (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		match     = chk_s1 && (ram_rdata == val_q);
		scan_done = !chk_s1 && (scan_q >= member_count_q);
		has_room  = (member_count_q < CW'(CAPACITY));
		out_free  = !res_valid_q || !res_stall;
		q_pop     = (state_q == ST_IDLE) && q_valid;
		ram_raddr = (state_q == ST_SHIFT) ? sh_q[AW-1:0] : scan_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = val_q;
		case (state_q)
			ST_SCAN: begin
				if (!match && scan_done && (cmd_q == CMD_ADD) && has_room) begin
					ram_we    = 1'b1;
					ram_waddr = member_count_q[AW-1:0];
				end
			end
			ST_SHIFT: begin
				if (wr_s1) begin
					ram_we    = 1'b1;
					ram_waddr = wr_addr_s1[AW-1:0];
					ram_wdata = ram_rdata;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign hit       = res_hit_q;
	assign count     = res_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			member_count_q <= '0;
			chk_s1         <= 1'b0;
			wr_s1          <= 1'b0;
			res_valid_q    <= 1'b0;
			cmd_q          <= CMD_ADD;
			val_q          <= '0;
			scan_q         <= '0;
			sh_q           <= '0;
			idx_s1         <= '0;
			wr_addr_s1     <= '0;
			hit_q          <= 1'b0;
			res_hit_q      <= 1'b0;
			res_count_q    <= '0;
		end else begin
			// In the response state the result register is reloaded whenever it frees up.
			if (res_valid_q && !res_stall && (state_q != ST_RESP)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cmd_q  <= q_data.cmd;
						val_q  <= q_data.value;
						scan_q <= '0;
						chk_s1 <= 1'b0;
						if (q_data.needs_scan) begin
							state_q <= ST_SCAN;
						end else begin
							member_count_q <= '0;
							hit_q          <= 1'b1;
							state_q        <= ST_RESP;
						end
					end
				end
				ST_SCAN: begin
					if (match) begin
						chk_s1 <= 1'b0;
						if (cmd_q == CMD_REMOVE) begin
							hit_q   <= 1'b1;
							sh_q    <= idx_s1 + 1'b1;
							wr_s1   <= 1'b0;
							state_q <= ST_SHIFT;
						end else begin
							hit_q   <= (cmd_q == CMD_QUERY);
							state_q <= ST_RESP;
						end
					end else if (scan_done) begin
						if ((cmd_q == CMD_ADD) && has_room) begin
							member_count_q <= member_count_q + 1'b1;
							hit_q          <= 1'b1;
						end else begin
							hit_q <= 1'b0;
						end
						state_q <= ST_RESP;
					end else if (scan_q < member_count_q) begin
						chk_s1 <= 1'b1;
						idx_s1 <= scan_q;
						scan_q <= scan_q + 1'b1;
					end else begin
						chk_s1 <= 1'b0;
					end
				end
				ST_SHIFT: begin
					wr_s1 <= (sh_q < member_count_q);
					if (sh_q < member_count_q) begin
						wr_addr_s1 <= sh_q - 1'b1;
						sh_q       <= sh_q + 1'b1;
					end else if (!wr_s1) begin
						member_count_q <= member_count_q - 1'b1;
						state_q        <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_hit_q   <= hit_q;
						res_count_q <= COUNT_W'(member_count_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sv/insertion_ordered_set_store_core.sv
// Order: a clear goes from idle straight to the response state; other requests scan first.
// A remove that finds its value then moves each later member down one place for the shift.
// Throughput: one request at a time in the back end, limited by the serial scan of the
// single-read-port member memory; a two-entry queue keeps accepting requests meanwhile.
// Reset: arst_n clears the count, the queue and the result register; the member memory
// is not cleared, since only entries below the count are ever read.
module insertion_ordered_set_store_core
	import isss_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [1:0]               cmd,
	input  logic signed [DATA_W-1:0] value,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic                     hit,
	output logic [COUNT_W-1:0]       count
);

	// The front end decodes each request and holds it in a short queue, so the
	// requester is only stalled when the queue is full.
	logic q_valid;
	logic q_pop;
	req_t q_data;

	isss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.value     (value),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_data    (q_data)
	);

	// The back end walks the packed members to find a match, appends on an add,
	// moves later members down on a remove, and holds each result in a register
	// until the consumer takes it.
	isss_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_data    (q_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.hit       (hit),
		.count     (count)
	);

endmodule
